### rtl/htb_pkg.sv
// Shared types, character constants and helper functions for the hex text
// to byte stream parser. No dependencies; imported by every rtl module.
`timescale 1ns / 1ps

package htb_pkg;

  // Parser phases. The enum is three bits wide; the spare code counts as an error.
  typedef enum logic [2:0] {
    PH_LEAD   = 3'd0,
    PH_ZERO   = 3'd1,
    PH_H      = 3'd2,
    PH_HE     = 3'd3,
    PH_OPEN   = 3'd4,
    PH_DIGITS = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] pending_nibble;
    logic       pending_valid;
    logic       paren_form;
    logic       failed;
  } pst_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_status;
    logic       accepted;
    logic       last;
  } res_t;

  // Everything that one input item produces: up to two results.
  typedef struct packed {
    logic [1:0] count;
    res_t       r0;
    res_t       r1;
  } pres_t;

  localparam pst_t PST_RESET = '{
    phase:          PH_LEAD,
    pending_nibble: 4'd0,
    pending_valid:  1'b0,
    paren_form:     1'b0,
    failed:         1'b0
  };

  localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CH_LOW_X  = 8'h78;  // 'x'
  localparam logic [7:0] CH_UP_H   = 8'h48;  // 'H'
  localparam logic [7:0] CH_UP_E   = 8'h45;  // 'E'
  localparam logic [7:0] CH_UP_X   = 8'h58;  // 'X'
  localparam logic [7:0] CH_OPEN   = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE  = 8'h29;  // ')'
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Returns {valid, value}; valid is low for anything that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      r = {1'b1, c[3:0]};
    end else if (((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
                 ((c >= CH_UP_A) && (c <= CH_UP_F))) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

### rtl/hex_text_to_byte_stream_parser_top.sv
// Top level of the hex text to byte stream parser: input register, parser
// state, and a two-slot result buffer. Depends on htb_pkg and htb_parse.
`timescale 1ns / 1ps

// Usage
// The input channel (char_valid, char_stall, character, end_of_string) takes
// one character per item, or an end item that closes the string. The result
// channel (result_valid, result_stall, byte_value, is_status, accepted, last)
// gives each decoded byte as it completes and, for the end item, a status
// result whose accepted bit says whether the string was well formed; last
// marks the final result caused by an item.
// An accepted item sits in the input register, where the parse step runs,
// until the buffer has room for its results, which are then registered.
// One item is taken per cycle unless the input is stalled. An end item that
// flushes a lone digit gives two results; the second waits in the buffer, so
// the input is not held while the receiver keeps taking a result every cycle.
// When the receiver stalls, results wait in a two-slot buffer; the input is
// stalled only when the buffer has no room for what the next item produces.
// Reset clears the parser to its leading whitespace phase and empties the
// input register and the result buffer; after each end item the parser
// returns to that same state by itself.

module hex_text_to_byte_stream_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] character,
  input  logic       end_of_string,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [7:0] byte_value,
  output logic       is_status,
  output logic       accepted,
  output logic       last
);
  import htb_pkg::*;

  // Input register.
  logic       in_v;
  logic [7:0] in_char;
  logic       in_eos;

  // Parser state.
  pst_t st;
  pst_t st_next;
  pres_t pres;

  // Result buffer: slot0 is the head; slot1 is used only when slot0 is.
  res_t slot0, slot1, slot0_next, slot1_next;
  logic v0, v1, v0_next, v1_next;

  logic       pop;
  logic [1:0] kept;
  logic [1:0] added;
  logic       fire;
  logic       take;

  htb_parse u_parse (
    .st            (st),
    .character     (in_char),
    .end_of_string (in_eos),
    .st_next       (st_next),
    .res           (pres)
  );

  assign pop  = v0 && !result_stall;
  assign kept = 2'({1'b0, v0} + {1'b0, v1} - {1'b0, pop});
  assign fire = in_v && ((3'({1'b0, kept}) + 3'({1'b0, pres.count})) <= 3'd2);
  assign added = fire ? pres.count : 2'd0;

  assign char_stall = in_v && !fire;
  assign take       = char_valid && !char_stall;

  always_comb begin
    slot0_next = slot0;
    slot1_next = slot1;
    unique case (kept)
      2'd0: begin
        slot0_next = pres.r0;
        slot1_next = pres.r1;
      end
      2'd1: begin
        // The surviving entry moves to the head if the old head just left.
        slot0_next = pop ? slot1 : slot0;
        slot1_next = pres.r0;
      end
      default: begin
        slot0_next = slot0;
        slot1_next = slot1;
      end
    endcase
    v0_next = (3'({1'b0, kept}) + 3'({1'b0, added})) >= 3'd1;
    v1_next = (3'({1'b0, kept}) + 3'({1'b0, added})) >= 3'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
      st   <= PST_RESET;
      v0   <= 1'b0;
      v1   <= 1'b0;
    end else begin
      if (take) begin
        in_v <= 1'b1;
      end else if (fire) begin
        in_v <= 1'b0;
      end
      if (fire) begin
        st <= st_next;
      end
      v0 <= v0_next;
      v1 <= v1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_char <= character;
      in_eos  <= end_of_string;
    end
    slot0 <= slot0_next;
    slot1 <= slot1_next;
  end

  assign result_valid = v0;
  assign byte_value   = slot0.byte_value;
  assign is_status    = slot0.is_status;
  assign accepted     = slot0.accepted;
  assign last         = slot0.last;

endmodule

### rtl/htb_parse.sv
// Combinational parse step: next parser state and the results of one item.
// Depends on htb_pkg.
`timescale 1ns / 1ps

module htb_parse (
  input  htb_pkg::pst_t  st,
  input  logic [7:0]     character,
  input  logic           end_of_string,
  output htb_pkg::pst_t  st_next,
  output htb_pkg::pres_t res
);
  import htb_pkg::*;

  logic       sp;
  logic [4:0] nib;
  logic       ok;

  assign sp  = is_space(character);
  assign nib = hex_nibble(character);
  assign ok  = !st.failed &&
               (((st.phase == PH_DIGITS) && !st.paren_form) || (st.phase == PH_TRAIL));

  // Next state.
  always_comb begin
    st_next = st;
    if (end_of_string) begin
      st_next = PST_RESET;
    end else if (!st.failed) begin
      unique case (st.phase)
        PH_LEAD: begin
          if (!sp) begin
            priority if (character == CH_ZERO) st_next.phase = PH_ZERO;
            else if (character == CH_UP_H)     st_next.phase = PH_H;
            else                               st_next.failed = 1'b1;
          end
        end
        PH_ZERO: begin
          if (character == CH_LOW_X) st_next.phase = PH_DIGITS;
          else                       st_next.failed = 1'b1;
        end
        PH_H: begin
          if (character == CH_UP_E) st_next.phase = PH_HE;
          else                      st_next.failed = 1'b1;
        end
        PH_HE: begin
          if (character == CH_UP_X) st_next.phase = PH_OPEN;
          else                      st_next.failed = 1'b1;
        end
        PH_OPEN: begin
          if (!sp) begin
            if (character == CH_OPEN) begin
              st_next.paren_form = 1'b1;
              st_next.phase      = PH_DIGITS;
            end else begin
              st_next.failed = 1'b1;
            end
          end
        end
        PH_DIGITS: begin
          if (!sp) begin
            if (nib[4]) begin
              if (st.pending_valid) begin
                st_next.pending_valid  = 1'b0;
                st_next.pending_nibble = 4'd0;
              end else begin
                st_next.pending_valid  = 1'b1;
                st_next.pending_nibble = nib[3:0];
              end
            end else begin
              // A non-digit flushes any lone digit, then only ')' may end the list.
              st_next.pending_valid  = 1'b0;
              st_next.pending_nibble = 4'd0;
              if (st.paren_form && (character == CH_CLOSE)) st_next.phase = PH_TRAIL;
              else                                          st_next.failed = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (!sp) st_next.failed = 1'b1;
        end
        default: st_next.failed = 1'b1;
      endcase
    end
  end

  // Results.
  always_comb begin
    res = '0;
    if (end_of_string) begin
      if (!st.failed && (st.phase == PH_DIGITS) && st.pending_valid) begin
        res.count         = 2'd2;
        res.r0.byte_value = {4'd0, st.pending_nibble};
        res.r1.is_status  = 1'b1;
        res.r1.accepted   = ok;
        res.r1.last       = 1'b1;
      end else begin
        res.count        = 2'd1;
        res.r0.is_status = 1'b1;
        res.r0.accepted  = ok;
        res.r0.last      = 1'b1;
      end
    end else if (!st.failed && (st.phase == PH_DIGITS) && !sp && st.pending_valid) begin
      res.count      = 2'd1;
      res.r0.last    = 1'b1;
      res.r0.byte_value = nib[4] ? {st.pending_nibble, nib[3:0]}
                                 : {4'd0, st.pending_nibble};
    end
  end

endmodule

### test/tb_top.sv
// Self-checking testbench for hex_text_to_byte_stream_parser_top: a predictor of the parser
// checks every byte and status result against the block. Depends on htb_pkg and the rtl.
`timescale 1ns / 1ps

module tb_top;
  import htb_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 64;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_status;
    logic       accepted;
    logic       last;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       char_valid = 1'b0;
  logic       char_stall;
  logic [7:0] character = 8'h00;
  logic       end_of_string = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [7:0] byte_value;
  logic       is_status;
  logic       accepted;
  logic       last;

  hex_text_to_byte_stream_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .char_valid    (char_valid),
    .char_stall    (char_stall),
    .character     (character),
    .end_of_string (end_of_string),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .byte_value    (byte_value),
    .is_status     (is_status),
    .accepted      (accepted),
    .last          (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  char_item_t pending_chars[$];
  outcome_t   results_due[$];
  int         items_queued = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         holds_requested = 0;
  int         holds_served = 0;
  int         hold_left = 0;
  logic       char_taken = 1'b0;
  int         quiet_cycles = 0;
  int         error_count = 0;
  int         chars_in = 0;
  int         ends_in = 0;
  int         bytes_out = 0;
  int         status_out = 0;
  int         good_strings = 0;

  // Predictor state for the string currently being parsed.
  phase_t     scan_phase = PH_LEAD;
  logic [3:0] held_nibble = 4'd0;
  logic       nibble_held = 1'b0;
  logic       closing_paren_due = 1'b0;
  logic       string_failed = 1'b0;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Returns {is_digit, value}.
  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) return {1'b1, 4'(c - CH_ZERO)};
    if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) return {1'b1, 4'(c - CH_LOW_A + 8'd10)};
    if ((c >= CH_UP_A) && (c <= CH_UP_F)) return {1'b1, 4'(c - CH_UP_A + 8'd10)};
    return 5'd0;
  endfunction

  function automatic outcome_t byte_outcome(input logic [7:0] v);
    return '{byte_value: v, is_status: 1'b0, accepted: 1'b0, last: 1'b0};
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic eos);
    outcome_t   found[$];
    logic [4:0] dv;
    logic       ok;
    dv = digit_value(c);
    if (eos) begin
      if (!string_failed && (scan_phase == PH_DIGITS) && nibble_held) begin
        found.push_back(byte_outcome({4'h0, held_nibble}));
      end
      ok = !string_failed && (((scan_phase == PH_DIGITS) && !closing_paren_due) ||
                              (scan_phase == PH_TRAIL));
      found.push_back('{byte_value: 8'h00, is_status: 1'b1, accepted: ok, last: 1'b0});
      scan_phase = PH_LEAD;
      held_nibble = 4'd0;
      nibble_held = 1'b0;
      closing_paren_due = 1'b0;
      string_failed = 1'b0;
    end else if (!string_failed) begin
      case (scan_phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == CH_ZERO) scan_phase = PH_ZERO;
            else if (c == CH_UP_H) scan_phase = PH_H;
            else string_failed = 1'b1;
          end
        end
        PH_ZERO: begin
          if (c == CH_LOW_X) scan_phase = PH_DIGITS;
          else string_failed = 1'b1;
        end
        PH_H: begin
          if (c == CH_UP_E) scan_phase = PH_HE;
          else string_failed = 1'b1;
        end
        PH_HE: begin
          if (c == CH_UP_X) scan_phase = PH_OPEN;
          else string_failed = 1'b1;
        end
        PH_OPEN: begin
          if (!is_blank(c)) begin
            if (c == CH_OPEN) begin
              closing_paren_due = 1'b1;
              scan_phase = PH_DIGITS;
            end else begin
              string_failed = 1'b1;
            end
          end
        end
        PH_DIGITS: begin
          if (!is_blank(c)) begin
            if (dv[4]) begin
              if (nibble_held) begin
                found.push_back(byte_outcome({held_nibble, dv[3:0]}));
                nibble_held = 1'b0;
                held_nibble = 4'd0;
              end else begin
                held_nibble = dv[3:0];
                nibble_held = 1'b1;
              end
            end else begin
              // A lone digit is flushed before the terminating character is judged.
              if (nibble_held) begin
                found.push_back(byte_outcome({4'h0, held_nibble}));
                nibble_held = 1'b0;
                held_nibble = 4'd0;
              end
              if (closing_paren_due && (c == CH_CLOSE)) scan_phase = PH_TRAIL;
              else string_failed = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (!is_blank(c)) string_failed = 1'b1;
        end
        default: begin
          string_failed = 1'b1;
        end
      endcase
    end
    if (found.size() > 0) found[found.size() - 1].last = 1'b1;
    foreach (found[i]) results_due.push_back(found[i]);
  endtask

  task automatic push_char(input logic [7:0] c);
    pending_chars.push_back('{ch: c, eos: 1'b0});
    items_queued++;
  endtask

  // The character field of an end item is ignored, so it carries noise.
  task automatic push_end();
    pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), eos: 1'b1});
    items_queued++;
  endtask

  function automatic logic [7:0] blank_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(CH_ZERO + v);
    return ($urandom_range(0, 1) != 0) ? 8'(CH_UP_A + v - 10) : 8'(CH_LOW_A + v - 10);
  endfunction

  // Mostly well-formed strings with random digits and spacing; some have one
  // character corrupted or are cut short, and a few are pure noise.
  task automatic push_random_string();
    logic [7:0] text[$];
    int         kind;
    int         ndig;
    int         k;
    logic       hex_form;
    kind = $urandom_range(0, 9);
    hex_form = 1'($urandom_range(0, 1));
    repeat ($urandom_range(0, 2)) text.push_back(blank_char());
    if (hex_form) begin
      text.push_back(CH_UP_H);
      text.push_back(CH_UP_E);
      text.push_back(CH_UP_X);
      repeat ($urandom_range(0, 2)) text.push_back(blank_char());
      text.push_back(CH_OPEN);
    end else begin
      text.push_back(CH_ZERO);
      text.push_back(CH_LOW_X);
    end
    ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 12);
    for (int i = 0; i < ndig; i++) begin
      if ($urandom_range(0, 5) == 0) text.push_back(blank_char());
      text.push_back(hex_char());
    end
    if (hex_form) text.push_back(CH_CLOSE);
    repeat ($urandom_range(0, 2)) text.push_back(blank_char());
    if ((kind == 7) || (kind == 8)) begin
      k = $urandom_range(0, text.size() - 1);
      if (kind == 7) text[k] = 8'($urandom_range(0, 255));
      else while (text.size() > k) void'(text.pop_back());
    end else if (kind == 9) begin
      text.delete();
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end
    foreach (text[i]) push_char(text[i]);
    push_end();
  endtask

  task automatic fill_random(input int count);
    int target;
    target = items_queued + count;
    while (items_queued < target) push_random_string();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while ((pending_chars.size() != 0) || char_valid || (results_due.size() != 0));
  endtask

  // Sender: a new item is offered only once the previous one has been taken.
  always @(negedge clk) begin : driver
    char_item_t it;
    if (rst) begin
      char_valid <= 1'b0;
    end else if (!char_valid || char_taken) begin
      if ((pending_chars.size() > 0) && ($urandom_range(0, 99) >= send_idle_pct)) begin
        it = pending_chars.pop_front();
        char_valid <= 1'b1;
        character <= it.ch;
        end_of_string <= it.eos;
      end else begin
        char_valid <= 1'b0;
        character <= 8'($urandom_range(0, 255));
        end_of_string <= 1'($urandom_range(0, 1));
      end
    end
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin : receiver
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holds_served != holds_requested) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    outcome_t want;
    char_taken = 1'b0;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        char_taken = 1'b1;
        decode_char(character, end_of_string);
        if (end_of_string) ends_in++;
        else chars_in++;
      end
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: byte_value %02h is_status %0b accepted %0b last %0b",
                 byte_value, is_status, accepted, last);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (byte_value !== want.byte_value) begin
            $error("byte_value: expected %02h, got %02h", want.byte_value, byte_value);
            error_count++;
          end
          if (is_status !== want.is_status) begin
            $error("is_status: expected %0b, got %0b", want.is_status, is_status);
            error_count++;
          end
          if (accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, accepted);
            error_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            error_count++;
          end
          if (want.is_status) begin
            status_out++;
            if (want.accepted) good_strings++;
          end else begin
            bytes_out++;
          end
        end
      end
      if (char_taken || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 50;

    // Whitespace lead-in, a full pair and a lone digit flushed by the end item.
    push_char(CH_SPACE);
    push_char(CH_TAB);
    push_char(CH_ZERO);
    push_char(CH_LOW_X);
    push_char(8'h31);
    push_char(CH_UP_F);
    push_char(CH_LOW_A);
    push_end();
    // The bracketed form with nothing inside it is still well formed.
    push_char(CH_UP_H);
    push_char(CH_UP_E);
    push_char(CH_UP_X);
    push_char(CH_SPACE);
    push_char(CH_OPEN);
    push_char(CH_CLOSE);
    push_end();
    // A lone digit before a non-ASCII character is emitted, then the error sticks.
    push_char(CH_ZERO);
    push_char(CH_LOW_X);
    push_char(8'h37);
    push_char(8'hFF);
    push_char(CH_UP_A);
    push_end();
    // A NUL at the start is an ordinary bad character.
    push_char(8'h00);
    push_end();

    fill_random(380);
    wait_drained();

    send_idle_pct = 50;
    recv_idle_pct = 16;
    fill_random(400);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Hold the results back while a long string keeps arriving.
    holds_requested++;
    push_char(CH_ZERO);
    push_char(CH_LOW_X);
    repeat (48) push_char(hex_char());
    push_end();
    fill_random(60);
    wait_drained();
    fill_random(330);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d characters in %0d strings, from which %0d bytes were decoded;",
             chars_in, ends_in, bytes_out);
    $display("%0d status results were checked, %0d of them for well-formed strings.",
             status_out, good_strings);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
